[hdl/lct_pkg.sv]
// Shared types, constants and codes for the chunk tag cache.
// Used by every module in the hdl folder. No dependencies.
package lct_pkg;

  // Store size and derived widths
  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned IDX_W           = $clog2(ENTRIES);
  localparam int unsigned CNT_W           = $clog2(ENTRIES + 1);
  localparam int unsigned MAX_CHUNK_BYTES = 4096;
  localparam int unsigned SHIFT_MAX       = $clog2(MAX_CHUNK_BYTES);
  localparam int unsigned SKIP_W          = 12;
  localparam int unsigned LEN_W           = 13;
  localparam int unsigned FILE_W          = 32;
  localparam int unsigned OFF_W           = 32;
  localparam int unsigned MODE_W          = 2;

  // Configuration register widths
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned MAXE_W    = 5;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_SHIFT = 1'b0,
    CFG_MAX_ENTRIES = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SORT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FRONT,
    OP_KILL,
    OP_SWAP
  } cell_op_e;

  // One recency position: physical slot and its tag
  typedef struct packed {
    logic              live;
    logic [IDX_W-1:0]  slot;
    logic [FILE_W-1:0] file;
    logic [OFF_W-1:0]  base;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  pos;
    logic              clear_tail;
    logic              phase;
    logic [FILE_W-1:0] file;
    logic [OFF_W-1:0]  base;
  } cell_ctl_t;

endpackage

[hdl/lct_cell.sv]
// One recency position of the chunk tag chain.
// Depends on lct_pkg for the entry and control structs.
module lct_cell
  import lct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  entry_t           left_i,
  input  entry_t           right_i,
  input  entry_t           front_i,
  output entry_t           ent_o,
  output logic             match_o,
  output logic             drop_o
);

  logic              live_q, live_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [FILE_W-1:0] file_q, file_d;
  logic [OFF_W-1:0]  base_q, base_d;
  logic [LEN_W-1:0]  len_q, len_d;
  entry_t            cur;
  entry_t            nxt;
  logic              file_eq;
  logic              is_first;
  logic              is_last;

  assign cur      = '{live: live_q, slot: slot_q, file: file_q, base: base_q, len: len_q};
  assign ent_o    = cur;
  assign is_first = (idx_i == '0);
  assign is_last  = (idx_i == IDX_W'(ENTRIES - 1));

  // Compare the held tag against the request
  assign file_eq = (file_q == ctl_i.file);
  assign match_o = live_q && file_eq && (base_q == ctl_i.base);
  assign drop_o  = live_q && file_eq;

  // Pick the next content of this position
  always_comb begin
    nxt = cur;
    case (ctl_i.op)
      OP_FRONT: begin
        if (is_first) begin
          nxt = front_i;
        end else if (idx_i <= ctl_i.pos) begin
          nxt = left_i;
        end else if (ctl_i.clear_tail) begin
          nxt.live = 1'b0;
        end
      end
      OP_KILL: begin
        if (drop_o) begin
          nxt.live = 1'b0;
        end
      end
      OP_SWAP: begin
        // pair (i, i+1) is active when bit 0 of i equals the phase
        if ((idx_i[0] == ctl_i.phase) && !is_last && !live_q && right_i.live) begin
          nxt = right_i;
        end else if ((idx_i[0] != ctl_i.phase) && !is_first && !left_i.live && live_q) begin
          nxt = left_i;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign live_d = nxt.live;
  assign slot_d = nxt.slot;
  assign file_d = nxt.file;
  assign base_d = nxt.base;
  assign len_d  = nxt.len;

  // Hold live flag and slot number; reset gives identity order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      slot_q <= idx_i;
    end else begin
      live_q <= live_d;
      slot_q <= slot_d;
    end
  end

  // Hold tag payload, meaningful only while live
  always_ff @(posedge clk_i) begin
    file_q <= file_d;
    base_q <= base_d;
    len_q  <= len_d;
  end

endmodule

[hdl/lct_ctrl.sv]
// Sequencer of the chunk tag cache: config registers, request capture,
// match/sort/finish steps and the result register. Depends on lct_pkg.
module lct_ctrl
  import lct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [FILE_W-1:0] file_id_i,
  input  logic [OFF_W-1:0]  byte_offset_i,
  input  logic [LEN_W-1:0]  request_bytes_i,
  input  logic [LEN_W-1:0]  fill_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [IDX_W-1:0]  slot_o,
  output logic [SKIP_W-1:0] skip_o,
  output logic [LEN_W-1:0]  length_o,
  output logic [OFF_W-1:0]  chunk_base_o,
  output logic [CNT_W-1:0]  removed_o,
  input  entry_t            ents_i [ENTRIES],
  input  logic [ENTRIES-1:0] match_i,
  input  logic [ENTRIES-1:0] drop_i,
  output cell_ctl_t         ctl_o,
  output entry_t            front_o
);

  state_e            state_q, state_d;
  logic [SHIFT_W-1:0] shift_q;
  logic [MAXE_W-1:0] maxe_q;
  logic [CNT_W-1:0]  live_cnt_q;
  logic              phase_q;
  logic [MODE_W-1:0] mode_q;
  logic [FILE_W-1:0] file_q;
  logic [OFF_W-1:0]  base_q;
  logic [SKIP_W-1:0] skip_q;
  logic [LEN_W-1:0]  req_q;
  logic [LEN_W-1:0]  fill_q;
  logic [ENTRIES-1:0] hit_vec_q;
  logic [CNT_W-1:0]  removed_q;

  logic              out_valid_q;
  logic              hit_q;
  logic [IDX_W-1:0]  slot_q;
  logic [SKIP_W-1:0] oskip_q;
  logic [LEN_W-1:0]  length_q;
  logic [OFF_W-1:0]  obase_q;
  logic [CNT_W-1:0]  oremoved_q;

  mode_e             md;
  logic              accept;
  logic              load;
  logic [SHIFT_W-1:0] shift_eff;
  logic [LEN_W-1:0]  csize;
  logic [SKIP_W-1:0] mask;
  logic [SKIP_W-1:0] in_skip;
  logic [OFF_W-1:0]  in_base;
  logic [LEN_W-1:0]  in_req;
  logic [LEN_W-1:0]  in_fill;
  logic [CNT_W-1:0]  drop_cnt;
  logic              need_swap;
  logic              any_hit;
  logic [IDX_W-1:0]  hit_pos;
  logic [CNT_W-1:0]  eff_max;
  logic [CNT_W-1:0]  lim;
  logic [IDX_W-1:0]  fill_pos;
  logic [CNT_W-1:0]  fill_removed;
  logic [IDX_W-1:0]  sel_pos;
  entry_t            sel;
  logic [LEN_W-1:0]  avail;
  logic [LEN_W-1:0]  hit_len;
  logic              res_hit;
  logic [IDX_W-1:0]  res_slot;
  logic [SKIP_W-1:0] res_skip;
  logic [LEN_W-1:0]  res_len;
  logic [OFF_W-1:0]  res_base;
  logic [CNT_W-1:0]  res_removed;

  assign md     = mode_e'(mode_q);
  assign accept = in_valid_i && in_ready_o;

  // Align the incoming offset and clip sizes to the chunk
  assign shift_eff = (shift_q > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift_q;
  assign csize     = LEN_W'(1) << shift_eff;
  assign mask      = SKIP_W'(csize - LEN_W'(1));
  assign in_skip   = byte_offset_i[SKIP_W-1:0] & mask;
  assign in_base   = byte_offset_i & ~{{(OFF_W - SKIP_W){1'b0}}, mask};
  assign in_req    = (request_bytes_i > csize) ? csize : request_bytes_i;
  assign in_fill   = (fill_bytes_i > csize) ? csize : fill_bytes_i;

  // Count entries of the invalidated file
  always_comb begin
    drop_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      drop_cnt = drop_cnt + CNT_W'(drop_i[i]);
    end
  end

  // Detect a free position ahead of a live one
  always_comb begin
    need_swap = 1'b0;
    for (int i = 0; i < ENTRIES - 1; i++) begin
      need_swap = need_swap | (!ents_i[i].live && ents_i[i + 1].live);
    end
  end

  // Find the most recent matching position
  always_comb begin
    hit_pos = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec_q[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end
  assign any_hit = |hit_vec_q;

  // Insert position for a fill, after eviction down to the limit
  always_comb begin
    if (maxe_q == '0) begin
      eff_max = CNT_W'(1);
    end else if (CNT_W'(maxe_q) > CNT_W'(ENTRIES)) begin
      eff_max = CNT_W'(ENTRIES);
    end else begin
      eff_max = CNT_W'(maxe_q);
    end
  end
  assign lim          = eff_max - CNT_W'(1);
  assign fill_pos     = (live_cnt_q > lim) ? lim[IDX_W-1:0] : live_cnt_q[IDX_W-1:0];
  assign fill_removed = live_cnt_q - CNT_W'(fill_pos);

  assign sel_pos = (md == MODE_FILL) ? fill_pos : hit_pos;
  assign sel     = ents_i[sel_pos];

  // Clip the request to what the entry holds past the skip
  assign avail   = (sel.len > LEN_W'(skip_q)) ? (sel.len - LEN_W'(skip_q)) : '0;
  assign hit_len = (req_q < avail) ? req_q : avail;

  // Form the result word
  always_comb begin
    res_hit     = 1'b0;
    res_slot    = '0;
    res_skip    = '0;
    res_len     = '0;
    res_base    = '0;
    res_removed = '0;
    case (md)
      MODE_LOOKUP: begin
        res_hit  = any_hit;
        res_slot = any_hit ? sel.slot : '0;
        res_skip = skip_q;
        res_len  = any_hit ? hit_len : '0;
        res_base = base_q;
      end
      MODE_FILL: begin
        res_slot    = sel.slot;
        res_skip    = skip_q;
        res_len     = fill_q;
        res_base    = base_q;
        res_removed = fill_removed;
      end
      MODE_INVAL: begin
        res_removed = removed_q;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_d = (md == MODE_INVAL) ? ST_SORT : ST_FINISH;
      end
      ST_SORT: begin
        if (!need_swap) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o       = 1'b0;
    load             = 1'b0;
    ctl_o.op         = OP_HOLD;
    ctl_o.pos        = sel_pos;
    ctl_o.clear_tail = (md == MODE_FILL);
    ctl_o.phase      = phase_q;
    ctl_o.file       = file_q;
    ctl_o.base       = base_q;
    front_o.live     = 1'b1;
    front_o.slot     = sel.slot;
    front_o.file     = (md == MODE_FILL) ? file_q : sel.file;
    front_o.base     = (md == MODE_FILL) ? base_q : sel.base;
    front_o.len      = (md == MODE_FILL) ? fill_q : sel.len;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MATCH: begin
        if (md == MODE_INVAL) begin
          ctl_o.op = OP_KILL;
        end
      end
      ST_SORT: begin
        if (need_swap) begin
          ctl_o.op = OP_SWAP;
        end
      end
      ST_FINISH: begin
        load = !out_valid_q || out_ready_i;
        if (load && (((md == MODE_LOOKUP) && any_hit) || (md == MODE_FILL))) begin
          ctl_o.op = OP_FRONT;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= SHIFT_W'(SHIFT_MAX);
      maxe_q      <= MAXE_W'(ENTRIES);
      live_cnt_q  <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CHUNK_SHIFT: shift_q <= cfg_data_i[SHIFT_W-1:0];
          CFG_MAX_ENTRIES: maxe_q  <= cfg_data_i[MAXE_W-1:0];
          default:         shift_q <= shift_q;
        endcase
      end
      if (accept) begin
        phase_q <= 1'b0;
      end else if (state_q == ST_SORT) begin
        phase_q <= !phase_q;
      end
      if ((state_q == ST_MATCH) && (md == MODE_INVAL)) begin
        live_cnt_q <= live_cnt_q - drop_cnt;
      end else if (load && (md == MODE_FILL)) begin
        live_cnt_q <= CNT_W'(fill_pos) + CNT_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      file_q <= file_id_i;
      base_q <= in_base;
      skip_q <= in_skip;
      req_q  <= in_req;
      fill_q <= in_fill;
    end
    if (state_q == ST_MATCH) begin
      hit_vec_q <= match_i;
      removed_q <= drop_cnt;
    end
    if (load) begin
      hit_q      <= res_hit;
      slot_q     <= res_slot;
      oskip_q    <= res_skip;
      length_q   <= res_len;
      obase_q    <= res_base;
      oremoved_q <= res_removed;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign slot_o       = slot_q;
  assign skip_o       = oskip_q;
  assign length_o     = length_q;
  assign chunk_base_o = obase_q;
  assign removed_o    = oremoved_q;

endmodule

[hdl/lru_chunk_tag_cache.sv]
// Chunk tag cache top level: a chain of recency cells and its sequencer.
// Depends on lct_pkg, lct_cell and lct_ctrl.
//
// Usage:
//   Requests arrive as words on the in channel (valid/ready) carrying mode,
//   file id, byte offset, request size and fill size. Each request yields
//   exactly one result word on the out channel (valid/ready).
//   Lookup and fill first compare all 16 cells in parallel, then shift the
//   chain and register the result. A new request is taken only once the
//   result is registered. Invalidate runs odd/even compaction passes of
//   the chain until it finds the chain compact.
//   Configuration (chunk shift at index 0, entry limit at index 1) is written
//   through cfg_we_i while no request is in flight.
//   Reset empties the store, restores identity slot order, sets chunk shift
//   to 12 and the entry limit to 16; no clearing sweep is needed.
//   A stalled receiver holds the result register; the chain waits in its
//   final step until the word is taken, while in_ready_o stays low.
module lru_chunk_tag_cache
  import lct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [FILE_W-1:0]    file_id_i,
  input  logic [OFF_W-1:0]     byte_offset_i,
  input  logic [LEN_W-1:0]     request_bytes_i,
  input  logic [LEN_W-1:0]     fill_bytes_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     slot_o,
  output logic [SKIP_W-1:0]    skip_o,
  output logic [LEN_W-1:0]     length_o,
  output logic [OFF_W-1:0]     chunk_base_o,
  output logic [CNT_W-1:0]     removed_o
);

  entry_t             ents [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] drop;
  cell_ctl_t          ctl;
  entry_t             front;

  // Sequencer
  lct_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .file_id_i       (file_id_i),
    .byte_offset_i   (byte_offset_i),
    .request_bytes_i (request_bytes_i),
    .fill_bytes_i    (fill_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .skip_o          (skip_o),
    .length_o        (length_o),
    .chunk_base_o    (chunk_base_o),
    .removed_o       (removed_o),
    .ents_i          (ents),
    .match_i         (match),
    .drop_i          (drop),
    .ctl_o           (ctl),
    .front_o         (front)
  );

  // Chain of recency cells, most recent at position 0
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;

    if (g == 0) begin : g_head
      assign left_ent = front;
    end else begin : g_body
      assign left_ent = ents[g - 1];
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[g + 1];
    end

    lct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left_ent),
      .right_i (right_ent),
      .front_i (front),
      .ent_o   (ents[g]),
      .match_o (match[g]),
      .drop_o  (drop[g])
    );
  end

endmodule

[hdl/lct_checker.sv]
// Port-level checks for the chunk tag cache, bound to the top level.
// Depends on lct_pkg and lru_chunk_tag_cache.
module lct_checker
  import lct_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 hit_o,
  input logic [IDX_W-1:0]     slot_o,
  input logic [SKIP_W-1:0]    skip_o,
  input logic [LEN_W-1:0]     length_o,
  input logic [OFF_W-1:0]     chunk_base_o,
  input logic [CNT_W-1:0]     removed_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(slot_o)
      && $stable(length_o) && $stable(chunk_base_o) && $stable(removed_o))
    else $error("result word changed while stalled");

  // Not ready in the cycle after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> removed_o == '0)
    else $error("hit reported with removed entries");

  // Skip and chunk base never overlap in the low bits
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chunk_base_o[SKIP_W-1:0] & skip_o) == '0)
    else $error("chunk base not aligned to skip");

  // Never remove more than the store holds
  a_removed_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> removed_o <= CNT_W'(ENTRIES))
    else $error("removed count beyond store size");

endmodule

bind lru_chunk_tag_cache lct_checker u_lct_checker (.*);

[bench/tb_lru_chunk_tag_cache.sv]
`timescale 1ns / 100ps
// Self-checking bench for the chunk tag cache: directed and random request words
// checked against a recency-ordered model of the tag store kept in the bench.
// Depends on lct_pkg and the lru_chunk_tag_cache RTL.
module tb_lru_chunk_tag_cache;
  import lct_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 50;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned SHIFT_PLAN [PHASES] = '{12, 0, 15, 4, 7, 7, 2, 13};
  localparam int unsigned LIMIT_PLAN [PHASES] = '{16, 1, 31, 0, 16, 3, 5, 20};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FILE_W-1:0] file;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  req_bytes;
    logic [LEN_W-1:0]  fill_bytes;
  } chunk_req_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  slot;
    logic [SKIP_W-1:0] skip;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  base;
    logic [CNT_W-1:0]  removed;
  } chunk_resp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [MODE_W-1:0]    mode_i;
  logic [FILE_W-1:0]    file_id_i;
  logic [OFF_W-1:0]     byte_offset_i;
  logic [LEN_W-1:0]     request_bytes_i;
  logic [LEN_W-1:0]     fill_bytes_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 hit_o;
  logic [IDX_W-1:0]     slot_o;
  logic [SKIP_W-1:0]    skip_o;
  logic [LEN_W-1:0]     length_o;
  logic [OFF_W-1:0]     chunk_base_o;
  logic [CNT_W-1:0]     removed_o;

  // Tag store model: slots listed most recent first, live ones at the head
  logic               tag_valid [ENTRIES];
  logic [FILE_W-1:0]  tag_file  [ENTRIES];
  logic [OFF_W-1:0]   tag_base  [ENTRIES];
  logic [LEN_W-1:0]   tag_len   [ENTRIES];
  int unsigned        lru_order [ENTRIES];
  int unsigned        live_cnt;
  logic [SHIFT_W-1:0] cur_shift;
  logic [MAXE_W-1:0]  cur_limit;

  chunk_resp_t pending_resp [$];
  int unsigned fail_count    = 0;
  int unsigned checked_words = 0;
  int unsigned lookup_hits   = 0;
  int unsigned fill_words    = 0;
  int unsigned inval_words   = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_count   = 0;
  int unsigned stall_left    = 0;
  logic        quiet         = 1'b0;

  lru_chunk_tag_cache DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .file_id_i       (file_id_i),
    .byte_offset_i   (byte_offset_i),
    .request_bytes_i (request_bytes_i),
    .fill_bytes_i    (fill_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .skip_o          (skip_o),
    .length_o        (length_o),
    .chunk_base_o    (chunk_base_o),
    .removed_o       (removed_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void clear_model();
    for (int i = 0; i < ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_file[i]  = '0;
      tag_base[i]  = '0;
      tag_len[i]   = '0;
      lru_order[i] = i;
    end
    live_cnt  = 0;
    cur_shift = SHIFT_W'(12);
    cur_limit = MAXE_W'(16);
  endfunction

  // Chunk size in bytes, shift clamped to the largest chunk the store holds
  function automatic int unsigned chunk_bytes();
    return 32'd1 << ((cur_shift > SHIFT_MAX) ? SHIFT_MAX : cur_shift);
  endfunction

  // Pull the slot at recency position pos to the front
  function automatic void move_front(int unsigned pos);
    int unsigned s;
    s = lru_order[pos];
    for (int unsigned p = pos; p > 0; p--)
      lru_order[p] = lru_order[p - 1];
    lru_order[0] = s;
  endfunction

  // Apply one request word to the model and return the result it gives
  function automatic chunk_resp_t cache_response(chunk_req_t r);
    chunk_resp_t      res;
    int unsigned      csize, lim, s, i;
    int unsigned      kept [$];
    int unsigned      gone [$];
    logic [OFF_W-1:0] skip_v, base_v;
    logic [LEN_W-1:0] want, got, avail;
    logic             found;
    csize  = chunk_bytes();
    skip_v = r.offset & OFF_W'(csize - 1);
    base_v = r.offset - skip_v;
    want   = (r.req_bytes > csize) ? LEN_W'(csize) : r.req_bytes;
    got    = (r.fill_bytes > csize) ? LEN_W'(csize) : r.fill_bytes;
    res    = '0;
    found  = 1'b0;
    case (r.mode)
      MODE_LOOKUP: begin
        for (i = 0; i < live_cnt && !found; i++) begin
          s = lru_order[i];
          if (tag_valid[s] && tag_file[s] == r.file && tag_base[s] == base_v) begin
            avail = (tag_len[s] > skip_v) ? tag_len[s] - LEN_W'(skip_v) : '0;
            found      = 1'b1;
            res.hit    = 1'b1;
            res.slot   = IDX_W'(s);
            res.length = (want < avail) ? want : avail;
            move_front(i);
          end
        end
        res.skip = SKIP_W'(skip_v);
        res.base = base_v;
      end
      MODE_FILL: begin
        lim = (cur_limit == 0) ? 0 : ((cur_limit > ENTRIES) ? ENTRIES - 1 : cur_limit - 1);
        // Evict from the least recent end until there is room
        while (live_cnt > lim) begin
          live_cnt = live_cnt - 1;
          tag_valid[lru_order[live_cnt]] = 1'b0;
          res.removed = res.removed + 1'b1;
        end
        s = lru_order[live_cnt];
        tag_valid[s] = 1'b1;
        tag_file[s]  = r.file;
        tag_base[s]  = base_v;
        tag_len[s]   = got;
        res.slot     = IDX_W'(s);
        res.length   = got;
        res.skip     = SKIP_W'(skip_v);
        res.base     = base_v;
        move_front(live_cnt);
        live_cnt = live_cnt + 1;
      end
      MODE_INVAL: begin
        // Keep survivors in order, park dropped slots behind them
        for (i = 0; i < live_cnt; i++) begin
          s = lru_order[i];
          if (tag_file[s] == r.file) begin
            tag_valid[s] = 1'b0;
            gone.push_back(s);
          end else begin
            kept.push_back(s);
          end
        end
        for (i = 0; i < kept.size(); i++)
          lru_order[i] = kept[i];
        for (i = 0; i < gone.size(); i++)
          lru_order[kept.size() + i] = gone[i];
        live_cnt    = kept.size();
        res.removed = CNT_W'(gone.size());
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_resp(input chunk_resp_t exp_r, input chunk_resp_t act_r);
    if (act_r.hit !== exp_r.hit) begin
      $error("hit: expected %0d, got %0d", exp_r.hit, act_r.hit);
      fail_count++;
    end
    if (act_r.slot !== exp_r.slot) begin
      $error("slot: expected %0d, got %0d", exp_r.slot, act_r.slot);
      fail_count++;
    end
    if (act_r.skip !== exp_r.skip) begin
      $error("skip: expected %0d, got %0d", exp_r.skip, act_r.skip);
      fail_count++;
    end
    if (act_r.length !== exp_r.length) begin
      $error("length: expected %0d, got %0d", exp_r.length, act_r.length);
      fail_count++;
    end
    if (act_r.base !== exp_r.base) begin
      $error("chunk_base: expected 0x%08h, got 0x%08h", exp_r.base, act_r.base);
      fail_count++;
    end
    if (act_r.removed !== exp_r.removed) begin
      $error("removed: expected %0d, got %0d", exp_r.removed, act_r.removed);
      fail_count++;
    end
  endtask

  // Predict on each accepted request word, check each accepted result word
  always @(posedge clk_i) begin : scoreboard
    chunk_resp_t exp_r;
    chunk_resp_t act_r;
    if (in_valid_i && in_ready_o) begin
      pending_resp.push_back(cache_response({mode_i, file_id_i, byte_offset_i,
                                             request_bytes_i, fill_bytes_i}));
      if (mode_i == MODE_FILL) fill_words++;
      if (mode_i == MODE_INVAL) inval_words++;
    end
    if (out_valid_o && out_ready_i) begin
      act_r = {hit_o, slot_o, skip_o, length_o, chunk_base_o, removed_o};
      if (pending_resp.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_resp.pop_front();
        compare_resp(exp_r, act_r);
        checked_words++;
        if (exp_r.hit) lookup_hits++;
      end
    end
  end

  // Gap length: none half the time, else mostly short and a few long
  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 15);
    if (pick < 8) return 0;
    if (pick < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_gap();
    end
  end

  function automatic chunk_req_t make_req(logic [MODE_W-1:0] mode, logic [FILE_W-1:0] file,
                                          logic [OFF_W-1:0] offset, logic [LEN_W-1:0] req,
                                          logic [LEN_W-1:0] fill);
    return {mode, file, offset, req, fill};
  endfunction

  // Drive one request word and hold it until accepted
  task automatic send_word(input chunk_req_t r);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    mode_i          <= r.mode;
    file_id_i       <= r.file;
    byte_offset_i   <= r.offset;
    request_bytes_i <= r.req_bytes;
    fill_bytes_i    <= r.fill_bytes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = idle_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CHUNK_SHIFT) cur_shift = value[SHIFT_W-1:0];
    else cur_limit = value[MAXE_W-1:0];
    reg_writes++;
  endtask

  function automatic logic [FILE_W-1:0] pick_file();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return $urandom();
      default: return FILE_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Offsets mostly fall in a few low chunks or the top one, so tags repeat
  function automatic logic [OFF_W-1:0] pick_offset();
    int unsigned      csize;
    logic [OFF_W-1:0] base_v;
    csize = chunk_bytes();
    if ($urandom_range(0, 9) == 0) return $urandom();
    if ($urandom_range(0, 5) == 5) base_v = ~OFF_W'(csize - 1);
    else base_v = OFF_W'($urandom_range(0, 4) * csize);
    return base_v | (OFF_W'($urandom()) & OFF_W'(csize - 1));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(0, 8191));
    return LEN_W'($urandom_range(0, chunk_bytes()));
  endfunction

  // Empty store after reset: a miss, and an unused mode with every bit set
  task automatic test_empty_cache();
    send_word(make_req(MODE_LOOKUP, '0, '0, '0, '0));
    send_word(make_req(MODE_UNUSED, '1, '1, '1, '1));
  endtask

  // Hits with clipping of the request, oversized fill and skip past the length
  task automatic test_hit_and_clip();
    send_word(make_req(MODE_FILL, '1, '1, 13'd0, 13'd8191));
    send_word(make_req(MODE_LOOKUP, '1, '1, 13'd8191, 13'd0));
    send_word(make_req(MODE_FILL, 32'd0, 32'h1000, 13'd0, 13'd100));
    send_word(make_req(MODE_LOOKUP, 32'd0, 32'h10C8, 13'd50, 13'd0));
    send_word(make_req(MODE_LOOKUP, 32'd0, 32'h1010, 13'd4096, 13'd0));
    send_word(make_req(MODE_FILL, 32'd1, 32'd0, 13'd0, 13'd0));
    send_word(make_req(MODE_LOOKUP, 32'd1, 32'd0, 13'd5, 13'd0));
  endtask

  // A second fill of one chunk shadows the first; invalidate drops both
  task automatic test_shadow_and_invalidate();
    send_word(make_req(MODE_FILL, 32'd0, 32'h1800, 13'd0, 13'd4096));
    send_word(make_req(MODE_LOOKUP, 32'd0, 32'h1000, 13'd0, 13'd0));
    send_word(make_req(MODE_INVAL, 32'd0, 32'h1234, 13'd7, 13'd9));
    send_word(make_req(MODE_LOOKUP, 32'd0, 32'h1000, 13'd16, 13'd0));
    send_word(make_req(MODE_INVAL, 32'd1234, '1, '1, '1));
    send_word(make_req(MODE_INVAL, '1, 32'h0000_0FFF, 13'd0, 13'd0));
    send_word(make_req(MODE_UNUSED, $urandom(), $urandom(), 13'h0AAA, 13'h1555));
  endtask

  // Lowering the entry limit evicts nothing until the next fill
  task automatic test_limit_lowered();
    wait_idle();
    write_reg(CFG_MAX_ENTRIES, CFG_W'(16));
    for (int f = 10; f < 14; f++)
      send_word(make_req(MODE_FILL, FILE_W'(f), 32'd0, 13'd0, 13'd64));
    wait_idle();
    write_reg(CFG_MAX_ENTRIES, CFG_W'(2));
    send_word(make_req(MODE_LOOKUP, 32'd10, 32'd8, 13'd64, 13'd0));
    send_word(make_req(MODE_FILL, 32'd14, 32'd0, 13'd0, 13'd32));
    send_word(make_req(MODE_LOOKUP, 32'd10, 32'd0, 13'd100, 13'd0));
  endtask

  // Random traffic over a sweep of register settings
  task automatic test_random_traffic();
    int unsigned      sent, roll, csize;
    logic             paused;
    logic [FILE_W-1:0] file;
    logic [OFF_W-1:0]  off;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      quiet = (phase == 0 || phase == 5);
      write_reg(CFG_CHUNK_SHIFT, CFG_W'(SHIFT_PLAN[phase]));
      write_reg(CFG_MAX_ENTRIES, CFG_W'(LIMIT_PLAN[phase]));
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        // Hold the sender once per phase until the pipeline drains
        if (sent >= PHASE_WORDS / 2 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        file  = pick_file();
        off   = pick_offset();
        csize = chunk_bytes();
        roll  = $urandom_range(0, 99);
        if (roll < 55) begin
          // Lookup, fill, then reuse of the same chunk
          send_word(make_req(MODE_LOOKUP, file, off, pick_len(), pick_len()));
          send_word(make_req(MODE_FILL, file, off, pick_len(), pick_len()));
          off = (off & ~OFF_W'(csize - 1)) | (OFF_W'($urandom()) & OFF_W'(csize - 1));
          send_word(make_req(MODE_LOOKUP, file, off, pick_len(), pick_len()));
          sent += 3;
        end else begin
          if (roll < 80) send_word(make_req(MODE_LOOKUP, file, off, pick_len(), pick_len()));
          else if (roll < 90) send_word(make_req(MODE_FILL, file, off, pick_len(), pick_len()));
          else if (roll < 96) send_word(make_req(MODE_INVAL, file, off, pick_len(), pick_len()));
          else send_word(make_req(MODE_UNUSED, $urandom(), $urandom(), LEN_W'($urandom()),
                                  LEN_W'($urandom())));
          sent++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_CHUNK_SHIFT;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_LOOKUP;
    file_id_i       = '0;
    byte_offset_i   = '0;
    request_bytes_i = '0;
    fill_bytes_i    = '0;
    out_ready_i     = 1'b0;
    clear_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_cache();
    test_hit_and_clip();
    test_shadow_and_invalidate();
    test_limit_lowered();
    test_random_traffic();

    // Drain, then give a stray result time to show up
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("Checked %0d result words: %0d lookup hits, %0d fills, %0d invalidates.",
             checked_words, lookup_hits, fill_words, inval_words);
    $display("Register writes: %0d, chunk shifts 0 to 15 and entry limits 0 to 31.",
             reg_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
